/* rtl/nrsh_pkg.sv */
// Shared types, widths, codes and helper functions for the nearest ray-segment hit block.
`default_nettype none
package nrsh_pkg;

  localparam int COORD_BITS   = 16;
  localparam int MAX_SEG_DEF  = 64;
  localparam int HALF_W       = COORD_BITS + 1;
  localparam int MUL_W        = COORD_BITS + 3;
  localparam int TERM_W       = 2 * COORD_BITS + 3;
  localparam int ACC_W        = 4 * COORD_BITS + 8;
  localparam int FRAC_BITS    = 16;
  localparam int RP_W         = 32;
  localparam int DVD_W        = TERM_W + ((COORD_BITS + 1 > FRAC_BITS) ? COORD_BITS + 1
                                                                      : FRAC_BITS);
  localparam int SEG_W        = 4 * COORD_BITS;
  localparam int STEP_W       = 5;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_HIT   = 2'd2,
    STAT_NOHIT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SEG,
    S_DIVT,
    S_PROD,
    S_DIVX,
    S_DIVY
  } state_t;

  typedef enum logic [1:0] {
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_mode_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_H,
    SH_2H
  } mac_sh_t;

  typedef struct packed {
    logic      en;
    mac_mode_t mode;
    mac_sh_t   sh;
  } mac_ctl_t;

  function automatic logic signed [MUL_W-1:0] half_lo(input logic signed [TERM_W-1:0] x);
    return $signed(MUL_W'(x[HALF_W-1:0]));
  endfunction

  function automatic logic signed [MUL_W-1:0] half_hi(input logic signed [TERM_W-1:0] x);
    return $signed(MUL_W'(x[TERM_W-1:HALF_W]));
  endfunction

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [DVD_W+1:0] v);
    logic signed [DVD_W+1:0] smax;
    logic signed [DVD_W+1:0] smin;
    smax = $signed({{(DVD_W + 3 - COORD_BITS){1'b0}}, {(COORD_BITS - 1){1'b1}}});
    smin = -smax - (DVD_W + 2)'(1);
    if (v > smax) begin
      return smax[COORD_BITS-1:0];
    end else if (v < smin) begin
      return smin[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/nrsh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module nrsh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/nrsh_mac.sv */
// Shared signed multiplier with a registered product and a shifting accumulator.
`default_nettype none
module nrsh_mac (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire nrsh_pkg::mac_ctl_t                   ctl,
  input  wire logic signed [nrsh_pkg::MUL_W-1:0]    op_a,
  input  wire logic signed [nrsh_pkg::MUL_W-1:0]    op_b,
  output logic signed      [nrsh_pkg::ACC_W-1:0]    acc
);

  logic signed [2*nrsh_pkg::MUL_W-1:0] prod_r;
  nrsh_pkg::mac_ctl_t                  ctl_r;
  logic signed [nrsh_pkg::ACC_W-1:0]   acc_r;
  logic signed [nrsh_pkg::ACC_W-1:0]   ext;
  logic signed [nrsh_pkg::ACC_W-1:0]   term;

  assign ext = nrsh_pkg::ACC_W'(prod_r);

  always_comb begin
    unique case (ctl_r.sh)
      nrsh_pkg::SH_0:  term = ext;
      nrsh_pkg::SH_H:  term = ext <<< nrsh_pkg::HALF_W;
      nrsh_pkg::SH_2H: term = ext <<< (2 * nrsh_pkg::HALF_W);
      default:         term = ext;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= op_a * op_b;
    end
    if (ctl_r.en) begin
      unique case (ctl_r.mode)
        nrsh_pkg::MAC_LOAD: acc_r <= term;
        nrsh_pkg::MAC_ADD:  acc_r <= acc_r + term;
        nrsh_pkg::MAC_SUB:  acc_r <= acc_r - term;
        default:            acc_r <= term;
      endcase
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

/* rtl/nrsh_div.sv */
// Unsigned restoring divider that produces one quotient bit per cycle.
`default_nettype none
module nrsh_div #(
  parameter int DVD_W = 52,
  parameter int DVS_W = 35
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [DVS_W:0]   rem_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;
  logic             ge;

  assign trial = {rem_r[DVS_W-1:0], quo_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !run_r) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(DVD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !run_r) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (run_r) begin
      rem_r <= ge ? (trial - {1'b0, dvs_r}) : trial;
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

/* rtl/nearest_ray_segment_hit.sv */
// Top level: segment table, query sequencer and result register of the nearest-hit block.
//
//   Channel   Ports                                   Handshake
//   request   in_op, in_end_*, in_origin_*, in_dir_*  taken when start is high and busy low
//   result    out_status, out_ray_param, out_hit_*,   one cycle, marked by out_valid
//             out_win_*
//
// Clear, add and an unused code answer one cycle after the request, and busy stays low.
// A query on a table of N segments fetches each of the N segments and evaluates it on
// the shared multiplier; if a hit is found, three divisions and two products follow.
// The divider and the single multiplier set how long a query takes.
// Reset is synchronous and empties the table; the table memory itself is not cleared.
// The receiver cannot stall, so a result is shown for exactly one cycle.
`default_nettype none
module nearest_ray_segment_hit #(
  parameter int MAX_SEGMENTS = nrsh_pkg::MAX_SEG_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic        [1:0]                     in_op,
  input  wire logic signed [nrsh_pkg::COORD_BITS-1:0] in_end_a_x,
  input  wire logic signed [nrsh_pkg::COORD_BITS-1:0] in_end_a_y,
  input  wire logic signed [nrsh_pkg::COORD_BITS-1:0] in_end_b_x,
  input  wire logic signed [nrsh_pkg::COORD_BITS-1:0] in_end_b_y,
  input  wire logic signed [nrsh_pkg::COORD_BITS-1:0] in_origin_x,
  input  wire logic signed [nrsh_pkg::COORD_BITS-1:0] in_origin_y,
  input  wire logic signed [nrsh_pkg::COORD_BITS-1:0] in_dir_x,
  input  wire logic signed [nrsh_pkg::COORD_BITS-1:0] in_dir_y,
  output logic                                       out_valid,
  output logic             [1:0]                     out_status,
  output logic             [nrsh_pkg::RP_W-1:0]      out_ray_param,
  output logic signed      [nrsh_pkg::COORD_BITS-1:0] out_hit_x,
  output logic signed      [nrsh_pkg::COORD_BITS-1:0] out_hit_y,
  output logic signed      [nrsh_pkg::COORD_BITS-1:0] out_win_a_x,
  output logic signed      [nrsh_pkg::COORD_BITS-1:0] out_win_a_y,
  output logic signed      [nrsh_pkg::COORD_BITS-1:0] out_win_b_x,
  output logic signed      [nrsh_pkg::COORD_BITS-1:0] out_win_b_y
);

  localparam int CB = nrsh_pkg::COORD_BITS;
  localparam int TW = nrsh_pkg::TERM_W;
  localparam int MW = nrsh_pkg::MUL_W;
  localparam int DW = nrsh_pkg::DVD_W;
  localparam int SW = nrsh_pkg::STEP_W;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  localparam logic [SW-1:0] K_OP0      = SW'(0);
  localparam logic [SW-1:0] K_OP1      = SW'(1);
  localparam logic [SW-1:0] K_OP2      = SW'(2);
  localparam logic [SW-1:0] K_OP3      = SW'(3);
  localparam logic [SW-1:0] K_OP4      = SW'(4);
  localparam logic [SW-1:0] K_OP5      = SW'(5);
  localparam logic [SW-1:0] K_CAP_LN   = SW'(7);
  localparam logic [SW-1:0] K_EVAL     = SW'(8);
  localparam logic [SW-1:0] K_CMP1     = SW'(9);
  localparam logic [SW-1:0] K_CMP2     = SW'(10);
  localparam logic [SW-1:0] K_CMP3     = SW'(11);
  localparam logic [SW-1:0] K_CMP4     = SW'(12);
  localparam logic [SW-1:0] K_CMP5     = SW'(13);
  localparam logic [SW-1:0] K_CMP6     = SW'(14);
  localparam logic [SW-1:0] K_CMP7     = SW'(15);
  localparam logic [SW-1:0] K_DECIDE   = SW'(17);
  localparam logic [SW-1:0] K_PROD_RDY = SW'(3);

  nrsh_pkg::state_t state_r, state_nxt;
  logic [SW-1:0]    step_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    idx_r;
  logic [CW-1:0]    idx_inc;

  logic signed [CB-1:0] px_r, py_r, vx_r, vy_r;
  logic signed [TW-1:0] det_r, tn_r, ln_r, btn_r, bdet_r;
  logic                 det_neg_r;
  logic                 found_r;
  logic                 sel_y_r;
  logic [nrsh_pkg::SEG_W-1:0] bseg_r;

  logic                       out_valid_r;
  nrsh_pkg::status_t          out_status_r;
  logic [nrsh_pkg::RP_W-1:0]  ray_r;
  logic signed [CB-1:0]       hx_r, hy_r;

  logic [nrsh_pkg::SEG_W-1:0] rd_data;
  logic signed [CB-1:0]       sax, say, sbx, sby;
  logic signed [CB:0]         dx, dy, rx, ry;
  logic signed [CB-1:0]       vsel, psel;
  logic signed [CB:0]         vsel_w;
  logic [CB:0]                abs_v;

  nrsh_pkg::mac_ctl_t         mac_ctl;
  logic signed [MW-1:0]       mac_a, mac_b;
  logic signed [nrsh_pkg::ACC_W-1:0] acc;
  logic signed [TW-1:0]       acc_t, acc_abs, acc_norm;

  logic                       div_start, div_done;
  logic [DW-1:0]              div_dvd, div_q;
  logic signed [DW+1:0]       hsum;
  logic [nrsh_pkg::RP_W-1:0]  rp_sat;

  logic accept, ram_we, full;
  logic cand_ok, take, seg_end, last_seg, found_after;

  assign accept   = start && !busy;
  assign full     = (count_r == CW'(MAX_SEGMENTS));
  assign ram_we   = accept && (in_op == nrsh_pkg::OP_ADD) && !full;
  assign idx_inc  = idx_r + CW'(1);
  assign last_seg = (idx_inc == count_r);

  nrsh_ram #(
    .WIDTH (nrsh_pkg::SEG_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IW-1:0]),
    .wdata ({in_end_a_x, in_end_a_y, in_end_b_x, in_end_b_y}),
    .raddr (idx_r[IW-1:0]),
    .rdata (rd_data)
  );

  assign sax = rd_data[4*CB-1:3*CB];
  assign say = rd_data[3*CB-1:2*CB];
  assign sbx = rd_data[2*CB-1:CB];
  assign sby = rd_data[CB-1:0];
  assign dx  = (CB+1)'(sax) - (CB+1)'(sbx);
  assign dy  = (CB+1)'(say) - (CB+1)'(sby);
  assign rx  = (CB+1)'(sax) - (CB+1)'(px_r);
  assign ry  = (CB+1)'(say) - (CB+1)'(py_r);

  assign vsel   = sel_y_r ? vy_r : vx_r;
  assign psel   = sel_y_r ? py_r : px_r;
  assign vsel_w = (CB+1)'(vsel);
  assign abs_v  = vsel[CB-1] ? unsigned'(-vsel_w) : unsigned'(vsel_w);

  nrsh_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .acc   (acc)
  );

  assign acc_t    = acc[TW-1:0];
  assign acc_abs  = acc[nrsh_pkg::ACC_W-1] ? -acc_t : acc_t;
  assign acc_norm = det_neg_r ? -acc_t : acc_t;

  assign cand_ok = (det_r != '0) && !tn_r[TW-1] && !ln_r[TW-1] && (ln_r <= det_r);
  assign take    = (state_r == nrsh_pkg::S_SEG) &&
                   (((step_r == K_EVAL) && cand_ok && !found_r) ||
                    ((step_r == K_DECIDE) && acc[nrsh_pkg::ACC_W-1]));
  assign seg_end = (state_r == nrsh_pkg::S_SEG) &&
                   (((step_r == K_EVAL) && (!cand_ok || !found_r)) ||
                    (step_r == K_DECIDE));
  assign found_after = found_r || take;

  assign div_dvd = (state_r == nrsh_pkg::S_DIVT) ?
                   (DW'(unsigned'(btn_r)) << nrsh_pkg::FRAC_BITS) : acc[DW-1:0];

  nrsh_div #(
    .DVD_W (DW),
    .DVS_W (TW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (unsigned'(bdet_r)),
    .done     (div_done),
    .quotient (div_q)
  );

  assign rp_sat = (|div_q[DW-1:nrsh_pkg::RP_W]) ? '1 : div_q[nrsh_pkg::RP_W-1:0];
  assign hsum   = (DW+2)'(psel) +
                  (vsel[CB-1] ? -$signed((DW+2)'(div_q)) : $signed((DW+2)'(div_q)));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nrsh_pkg::S_IDLE: begin
        if (accept && (in_op == nrsh_pkg::OP_QUERY) && (count_r != '0)) begin
          state_nxt = nrsh_pkg::S_FETCH;
        end
      end
      nrsh_pkg::S_FETCH: state_nxt = nrsh_pkg::S_SEG;
      nrsh_pkg::S_SEG: begin
        if (seg_end) begin
          if (!last_seg) begin
            state_nxt = nrsh_pkg::S_FETCH;
          end else if (found_after) begin
            state_nxt = nrsh_pkg::S_DIVT;
          end else begin
            state_nxt = nrsh_pkg::S_IDLE;
          end
        end
      end
      nrsh_pkg::S_DIVT: if (div_done) state_nxt = nrsh_pkg::S_PROD;
      nrsh_pkg::S_PROD: begin
        if (step_r == K_PROD_RDY) begin
          state_nxt = sel_y_r ? nrsh_pkg::S_DIVY : nrsh_pkg::S_DIVX;
        end
      end
      nrsh_pkg::S_DIVX: if (div_done) state_nxt = nrsh_pkg::S_PROD;
      nrsh_pkg::S_DIVY: if (div_done) state_nxt = nrsh_pkg::S_IDLE;
      default:          state_nxt = nrsh_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mac_ctl   = '{en: 1'b0, mode: nrsh_pkg::MAC_LOAD, sh: nrsh_pkg::SH_0};
    mac_a     = '0;
    mac_b     = '0;
    div_start = 1'b0;
    unique case (state_r)
      nrsh_pkg::S_SEG: begin
        unique case (step_r)
          K_OP0: begin
            mac_ctl = '{1'b1, nrsh_pkg::MAC_LOAD, nrsh_pkg::SH_0};
            mac_a = MW'(vx_r); mac_b = MW'(dy);
          end
          K_OP1: begin
            mac_ctl = '{1'b1, nrsh_pkg::MAC_SUB, nrsh_pkg::SH_0};
            mac_a = MW'(vy_r); mac_b = MW'(dx);
          end
          K_OP2: begin
            mac_ctl = '{1'b1, nrsh_pkg::MAC_LOAD, nrsh_pkg::SH_0};
            mac_a = MW'(rx); mac_b = MW'(dy);
          end
          K_OP3: begin
            mac_ctl = '{1'b1, nrsh_pkg::MAC_SUB, nrsh_pkg::SH_0};
            mac_a = MW'(ry); mac_b = MW'(dx);
          end
          K_OP4: begin
            mac_ctl = '{1'b1, nrsh_pkg::MAC_LOAD, nrsh_pkg::SH_0};
            mac_a = MW'(vx_r); mac_b = MW'(ry);
          end
          K_OP5: begin
            mac_ctl = '{1'b1, nrsh_pkg::MAC_SUB, nrsh_pkg::SH_0};
            mac_a = MW'(vy_r); mac_b = MW'(rx);
          end
          K_EVAL: begin
            mac_ctl = '{1'b1, nrsh_pkg::MAC_LOAD, nrsh_pkg::SH_0};
            mac_a = nrsh_pkg::half_lo(tn_r); mac_b = nrsh_pkg::half_lo(bdet_r);
          end
          K_CMP1: begin
            mac_ctl = '{1'b1, nrsh_pkg::MAC_ADD, nrsh_pkg::SH_H};
            mac_a = nrsh_pkg::half_lo(tn_r); mac_b = nrsh_pkg::half_hi(bdet_r);
          end
          K_CMP2: begin
            mac_ctl = '{1'b1, nrsh_pkg::MAC_ADD, nrsh_pkg::SH_H};
            mac_a = nrsh_pkg::half_hi(tn_r); mac_b = nrsh_pkg::half_lo(bdet_r);
          end
          K_CMP3: begin
            mac_ctl = '{1'b1, nrsh_pkg::MAC_ADD, nrsh_pkg::SH_2H};
            mac_a = nrsh_pkg::half_hi(tn_r); mac_b = nrsh_pkg::half_hi(bdet_r);
          end
          K_CMP4: begin
            mac_ctl = '{1'b1, nrsh_pkg::MAC_SUB, nrsh_pkg::SH_0};
            mac_a = nrsh_pkg::half_lo(btn_r); mac_b = nrsh_pkg::half_lo(det_r);
          end
          K_CMP5: begin
            mac_ctl = '{1'b1, nrsh_pkg::MAC_SUB, nrsh_pkg::SH_H};
            mac_a = nrsh_pkg::half_lo(btn_r); mac_b = nrsh_pkg::half_hi(det_r);
          end
          K_CMP6: begin
            mac_ctl = '{1'b1, nrsh_pkg::MAC_SUB, nrsh_pkg::SH_H};
            mac_a = nrsh_pkg::half_hi(btn_r); mac_b = nrsh_pkg::half_lo(det_r);
          end
          K_CMP7: begin
            mac_ctl = '{1'b1, nrsh_pkg::MAC_SUB, nrsh_pkg::SH_2H};
            mac_a = nrsh_pkg::half_hi(btn_r); mac_b = nrsh_pkg::half_hi(det_r);
          end
          default: mac_ctl = '{1'b0, nrsh_pkg::MAC_LOAD, nrsh_pkg::SH_0};
        endcase
      end
      nrsh_pkg::S_PROD: begin
        if (step_r == K_OP0) begin
          mac_ctl = '{1'b1, nrsh_pkg::MAC_LOAD, nrsh_pkg::SH_0};
          mac_a = $signed(MW'(abs_v)); mac_b = nrsh_pkg::half_lo(btn_r);
        end else if (step_r == K_OP1) begin
          mac_ctl = '{1'b1, nrsh_pkg::MAC_ADD, nrsh_pkg::SH_H};
          mac_a = $signed(MW'(abs_v)); mac_b = nrsh_pkg::half_hi(btn_r);
        end
      end
      nrsh_pkg::S_DIVT, nrsh_pkg::S_DIVX, nrsh_pkg::S_DIVY: begin
        div_start = (step_r == K_OP0);
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nrsh_pkg::S_IDLE;
      step_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      sel_y_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (accept && !((in_op == nrsh_pkg::OP_QUERY) && (count_r != '0))) ||
                     (seg_end && last_seg && !found_after) ||
                     ((state_r == nrsh_pkg::S_DIVY) && div_done);
      if (state_nxt != state_r) begin
        step_r <= '0;
      end else if ((state_r == nrsh_pkg::S_DIVT) || (state_r == nrsh_pkg::S_DIVX) ||
                   (state_r == nrsh_pkg::S_DIVY)) begin
        step_r <= K_OP1;
      end else begin
        step_r <= step_r + SW'(1);
      end
      if (accept) begin
        unique case (in_op)
          nrsh_pkg::OP_CLEAR: begin
            count_r <= '0;
          end
          nrsh_pkg::OP_ADD: begin
            if (!full) begin
              count_r <= count_r + CW'(1);
            end
          end
          nrsh_pkg::OP_QUERY: begin
            idx_r   <= '0;
            found_r <= 1'b0;
            sel_y_r <= 1'b0;
          end
          default: ;
        endcase
      end
      if (seg_end) begin
        found_r <= found_after;
        if (!last_seg) begin
          idx_r <= idx_inc;
        end
      end
      if ((state_r == nrsh_pkg::S_DIVX) && div_done) begin
        sel_y_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_origin_x;
      py_r <= in_origin_y;
      vx_r <= in_dir_x;
      vy_r <= in_dir_y;
      out_status_r <= ((in_op == nrsh_pkg::OP_ADD) && full) ? nrsh_pkg::STAT_FULL :
                      ((in_op == nrsh_pkg::OP_QUERY) ? nrsh_pkg::STAT_NOHIT
                                                     : nrsh_pkg::STAT_DONE);
      ray_r  <= '0;
      hx_r   <= '0;
      hy_r   <= '0;
      bseg_r <= '0;
    end
    if (state_r == nrsh_pkg::S_SEG) begin
      if (step_r == K_OP3) begin
        det_neg_r <= acc[nrsh_pkg::ACC_W-1];
        det_r     <= acc_abs;
      end
      if (step_r == K_OP5) begin
        tn_r <= acc_norm;
      end
      if (step_r == K_CAP_LN) begin
        ln_r <= acc_norm;
      end
    end
    if (take) begin
      btn_r  <= tn_r;
      bdet_r <= det_r;
      bseg_r <= rd_data;
    end
    if ((state_r == nrsh_pkg::S_DIVT) && div_done) begin
      ray_r        <= rp_sat;
      out_status_r <= nrsh_pkg::STAT_HIT;
    end
    if ((state_r == nrsh_pkg::S_DIVX) && div_done) begin
      hx_r <= nrsh_pkg::sat_coord(hsum);
    end
    if ((state_r == nrsh_pkg::S_DIVY) && div_done) begin
      hy_r <= nrsh_pkg::sat_coord(hsum);
    end
  end

  assign busy          = (state_r != nrsh_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_ray_param = ray_r;
  assign out_hit_x     = hx_r;
  assign out_hit_y     = hy_r;
  assign out_win_a_x   = bseg_r[4*CB-1:3*CB];
  assign out_win_a_y   = bseg_r[3*CB-1:2*CB];
  assign out_win_b_x   = bseg_r[2*CB-1:CB];
  assign out_win_b_y   = bseg_r[CB-1:0];

  a_done_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("query finished without a result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SEGMENTS))
    else $error("segment count beyond table size");

  a_query_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == nrsh_pkg::OP_QUERY) && (count_r != '0)) |=> (busy && !out_valid))
    else $error("query on a filled table did not start the walk");

endmodule
`default_nettype wire

/* tb/nearest_ray_segment_hit_tb.sv */
// Testbench for the nearest ray-segment hit block: directed and random requests checked
// against a built-in predictor.
`default_nettype none
module nearest_ray_segment_hit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 64;
  localparam int STALL_LIMIT = 20000;

  typedef logic signed [nrsh_pkg::COORD_BITS-1:0] coord_t;

  typedef struct packed {
    nrsh_pkg::status_t status;
    logic [31:0]  ray_param;
    coord_t       hit_x;
    coord_t       hit_y;
    coord_t       win_a_x;
    coord_t       win_a_y;
    coord_t       win_b_x;
    coord_t       win_b_y;
  } hit_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_op = nrsh_pkg::OP_CLEAR;
  coord_t in_end_a_x = '0, in_end_a_y = '0, in_end_b_x = '0, in_end_b_y = '0;
  coord_t in_origin_x = '0, in_origin_y = '0, in_dir_x = '0, in_dir_y = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [nrsh_pkg::RP_W-1:0] out_ray_param;
  coord_t out_hit_x, out_hit_y, out_win_a_x, out_win_a_y, out_win_b_x, out_win_b_y;

  nearest_ray_segment_hit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_end_a_x(in_end_a_x), .in_end_a_y(in_end_a_y),
    .in_end_b_x(in_end_b_x), .in_end_b_y(in_end_b_y),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y),
    .out_valid(out_valid), .out_status(out_status), .out_ray_param(out_ray_param),
    .out_hit_x(out_hit_x), .out_hit_y(out_hit_y),
    .out_win_a_x(out_win_a_x), .out_win_a_y(out_win_a_y),
    .out_win_b_x(out_win_b_x), .out_win_b_y(out_win_b_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  longint seg_ax[TABLE_DEPTH], seg_ay[TABLE_DEPTH], seg_bx[TABLE_DEPTH], seg_by[TABLE_DEPTH];
  int seg_count = 0;
  hit_reply_t pending_replies[$];
  int mismatches = 0;
  int stall_cycles = 0;
  bit gaps_on = 1'b1;
  bit accepted_now = 1'b0;

  function automatic coord_t clamp_coord(longint v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  function automatic hit_reply_t predict_reply(nrsh_pkg::op_t op, coord_t ax, coord_t ay,
                                               coord_t bx, coord_t by, coord_t px,
                                               coord_t py, coord_t vx, coord_t vy);
    hit_reply_t r;
    longint dx, dy, rx, ry, det, tn, ln, best_tn, best_det, q;
    bit found;
    int best_idx;
    logic [127:0] lhs, rhs;
    r = '0;
    r.status = nrsh_pkg::STAT_DONE;
    found = 1'b0;
    best_tn = 0;
    best_det = 1;
    best_idx = 0;
    case (op)
      nrsh_pkg::OP_CLEAR: seg_count = 0;
      nrsh_pkg::OP_ADD: begin
        if (seg_count >= TABLE_DEPTH) begin
          r.status = nrsh_pkg::STAT_FULL;
        end else begin
          seg_ax[seg_count] = ax;
          seg_ay[seg_count] = ay;
          seg_bx[seg_count] = bx;
          seg_by[seg_count] = by;
          seg_count++;
        end
      end
      nrsh_pkg::OP_QUERY: begin
        for (int i = 0; i < seg_count; i++) begin
          dx = seg_ax[i] - seg_bx[i];
          dy = seg_ay[i] - seg_by[i];
          rx = seg_ax[i] - longint'(px);
          ry = seg_ay[i] - longint'(py);
          det = longint'(vx) * dy - longint'(vy) * dx;
          tn = rx * dy - ry * dx;
          ln = longint'(vx) * ry - longint'(vy) * rx;
          if (det == 0) continue;
          if (det < 0) begin
            det = -det;
            tn = -tn;
            ln = -ln;
          end
          if (tn < 0 || ln < 0 || ln > det) continue;
          lhs = 128'(tn) * 128'(best_det);
          rhs = 128'(best_tn) * 128'(det);
          if (!found || lhs < rhs) begin
            found = 1'b1;
            best_tn = tn;
            best_det = det;
            best_idx = i;
          end
        end
        if (!found) begin
          r.status = nrsh_pkg::STAT_NOHIT;
        end else begin
          q = (best_tn <<< 16) / best_det;
          r.status = nrsh_pkg::STAT_HIT;
          r.ray_param = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
          r.hit_x = clamp_coord(longint'(px) + (longint'(vx) * best_tn) / best_det);
          r.hit_y = clamp_coord(longint'(py) + (longint'(vy) * best_tn) / best_det);
          r.win_a_x = coord_t'(seg_ax[best_idx]);
          r.win_a_y = coord_t'(seg_ay[best_idx]);
          r.win_b_x = coord_t'(seg_bx[best_idx]);
          r.win_b_y = coord_t'(seg_by[best_idx]);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(nrsh_pkg::op_t op, coord_t ax, coord_t ay, coord_t bx,
                              coord_t by, coord_t px, coord_t py, coord_t vx, coord_t vy);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_end_a_x <= ax;
    in_end_a_y <= ay;
    in_end_b_x <= bx;
    in_end_b_y <= by;
    in_origin_x <= px;
    in_origin_y <= py;
    in_dir_x <= vx;
    in_dir_y <= vy;
    do @(posedge clk); while (busy);
    accepted_now = 1'b1;
    pending_replies.insert(pending_replies.size(),
                           predict_reply(op, ax, ay, bx, by, px, py, vx, vy));
  endtask

  task automatic add_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    send_request(nrsh_pkg::OP_ADD, ax, ay, bx, by, coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom), coord_t'($urandom));
  endtask

  task automatic cast_ray(coord_t px, coord_t py, coord_t vx, coord_t vy);
    send_request(nrsh_pkg::OP_QUERY, coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom), coord_t'($urandom), px, py, vx, vy);
  endtask

  task automatic clear_table();
    send_request(nrsh_pkg::OP_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0);
  endtask

  function automatic coord_t random_coord();
    if ($urandom_range(0, 3) == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 16000)) - coord_t'(8000);
  endfunction

  task automatic test_basic_ops();
    cast_ray(16'sd0, 16'sd0, 16'sd256, 16'sd0);
    send_request(nrsh_pkg::OP_NONE, '1, '1, '1, '1, '1, '1, '1, '1);
    add_segment(16'sd512, -16'sd256, 16'sd512, 16'sd256);
    cast_ray(16'sd0, 16'sd0, 16'sd256, 16'sd0);
    cast_ray(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    cast_ray(16'sd0, 16'sd0, 16'sd0, 16'sd256);
    cast_ray(16'sd0, 16'sd0, -16'sd256, 16'sd0);
    cast_ray(16'sd0, 16'sd256, 16'sd256, 16'sd0);
    add_segment(16'sd512, -16'sd256, 16'sd512, 16'sd256);
    add_segment(16'sd100, 16'sd100, 16'sd100, 16'sd100);
    cast_ray(16'sd0, 16'sd0, 16'sd256, 16'sd0);
    clear_table();
    cast_ray(16'sd0, 16'sd0, 16'sd256, 16'sd0);
  endtask

  task automatic test_extremes();
    clear_table();
    add_segment(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    add_segment(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF);
    cast_ray(16'sh8000, 16'sd0, 16'sd1, 16'sd0);
    cast_ray(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
    cast_ray(16'sd0, 16'sd0, 16'sh7FFF, 16'sd1);
    cast_ray(16'sd0, 16'sd0, -16'sd1, 16'sd0);
    clear_table();
    add_segment(16'sd1, 16'sh8000, 16'sd1, 16'sh7FFF);
    cast_ray(16'sd0, 16'sd0, 16'sh7FFF, 16'sh7FFF);
  endtask

  task automatic test_full_table();
    clear_table();
    for (int i = 0; i < TABLE_DEPTH; i++) add_segment(random_coord(), random_coord(),
                                                      random_coord(), random_coord());
    add_segment(16'sd1, 16'sd2, 16'sd3, 16'sd4);
    cast_ray(random_coord(), random_coord(), random_coord(), random_coord());
    clear_table();
  endtask

  task automatic test_random_scenes();
    int n_segs, n_rays, k;
    coord_t px, py;
    longint mx, my;
    for (int items = 0; items < 2000; items += n_segs + n_rays + 1) begin
      if (items > 1700) gaps_on = 1'b0;
      n_segs = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 66) : $urandom_range(0, 8);
      n_rays = $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) begin
        send_request(nrsh_pkg::op_t'($urandom_range(0, 3)), random_coord(), random_coord(),
                     random_coord(), random_coord(), random_coord(), random_coord(),
                     random_coord(), random_coord());
      end else begin
        clear_table();
      end
      for (int i = 0; i < n_segs; i++) begin
        add_segment(random_coord(), random_coord(), random_coord(), random_coord());
      end
      for (int i = 0; i < n_rays; i++) begin
        px = coord_t'($urandom_range(0, 16000)) - coord_t'(8000);
        py = coord_t'($urandom_range(0, 16000)) - coord_t'(8000);
        k = (seg_count > 0) ? $urandom_range(0, seg_count - 1) : 0;
        mx = (seg_ax[k] + seg_bx[k]) / 2 - px;
        my = (seg_ay[k] + seg_by[k]) / 2 - py;
        if (seg_count > 0 && $urandom_range(0, 3) != 0) begin
          cast_ray(px, py, clamp_coord(mx), clamp_coord(my));
        end else begin
          cast_ray(random_coord(), random_coord(), random_coord(), random_coord());
        end
      end
    end
  endtask

  always @(posedge clk) begin
    hit_reply_t want, got;
    if (out_valid) begin
      got = {nrsh_pkg::status_t'(out_status), out_ray_param, out_hit_x, out_hit_y,
             out_win_a_x, out_win_a_y, out_win_b_x, out_win_b_y};
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: %p", got);
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid || accepted_now) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    accepted_now = 1'b0;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_extremes();
    test_full_table();
    test_random_scenes();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
rtl/nrsh_pkg.sv
rtl/nrsh_ram.sv
rtl/nrsh_mac.sv
rtl/nrsh_div.sv
rtl/nearest_ray_segment_hit.sv
tb/nearest_ray_segment_hit_tb.sv
